// ----- rtl/prd_pkg.sv -----
// Shared types and constants for the palette run-length decoder.
package prd_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int IDX_W               = 8;
  localparam int RGB_W               = 24;
  localparam int COUNT_W             = 8;
  localparam int PEND_W              = 7;

  localparam logic [1:0] MODE_PAL_WRITE = 2'd0;
  localparam logic [1:0] MODE_DATA      = 2'd1;
  localparam logic [1:0] MODE_RESTART   = 2'd2;

  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_REPEAT = 1'b1;

  localparam logic [IDX_W-1:0] FILL_INDEX = 8'hFF;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_RUNCOL  = 5'b00010,
    PH_FFLEN   = 5'b00100,
    PH_LITERAL = 5'b01000,
    PH_REPLEN  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] rgb;
  } pal_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } pal_rd_t;

endpackage

// ----- rtl/prd_palette.sv -----
// Palette memory with per-entry valid bits and a registered read port.
module prd_palette #(
  parameter int PALETTE_ENTRIES = prd_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  prd_pkg::pal_wr_t         wr,
  input  prd_pkg::pal_rd_t         rd,
  output logic [prd_pkg::RGB_W-1:0] rd_rgb
);

  localparam int AddrW = $clog2(PALETTE_ENTRIES);

  logic [prd_pkg::RGB_W-1:0] mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] vld;
  logic [prd_pkg::RGB_W-1:0] rd_data;
  logic                      rd_ok;
  logic                      wr_in_range;
  logic                      rd_in_range;
  logic [AddrW-1:0]          wr_addr;
  logic [AddrW-1:0]          rd_addr;

  assign wr_in_range = {1'b0, wr.idx} < (prd_pkg::IDX_W+1)'(PALETTE_ENTRIES);
  assign rd_in_range = {1'b0, rd.idx} < (prd_pkg::IDX_W+1)'(PALETTE_ENTRIES);
  assign wr_addr     = wr.idx[AddrW-1:0];
  assign rd_addr     = rd.idx[AddrW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr_addr] <= wr.rgb;
    end
    if (rd.en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr.en && wr_in_range) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_ok <= rd_in_range && vld[rd_addr];
      end
    end
  end

  assign rd_rgb = rd_ok ? rd_data : '0;

endmodule

// ----- rtl/palette_rle_run_decoder_unit.sv -----
// Top level of the palette run-length bitmap decoder.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid, in_ready  | mode, data_byte, pal_index, pal_red/green/blue
//   out     | output    | out_valid, out_ready| kind, red, green, blue, count
//
// One item per cycle unless the output stage stalls; a result shows the cycle after its coded
// byte, set by the registered palette read. Phase and pending count update at acceptance.
// Reset clears phase, pending count, palette valid bits and the result valid flag.
// A stalled result holds in the output stage; input is taken whenever that stage
// is empty or being drained in the same cycle.
module palette_rle_run_decoder_unit #(
  parameter int PALETTE_ENTRIES = prd_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [prd_pkg::IDX_W-1:0]   data_byte,
  input  logic [prd_pkg::IDX_W-1:0]   pal_index,
  input  logic [7:0]                  pal_red,
  input  logic [7:0]                  pal_green,
  input  logic [7:0]                  pal_blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        kind,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic [prd_pkg::COUNT_W-1:0] count
);

  prd_pkg::phase_t                  phase, phase_next;
  logic [prd_pkg::PEND_W-1:0]       pending, pending_next;
  logic                             accept;
  logic                             is_data;
  logic                             emit;
  logic                             emit_kind;
  logic [prd_pkg::IDX_W-1:0]        emit_idx;
  logic [prd_pkg::COUNT_W-1:0]      emit_count;
  logic                             s1_kind;
  logic [prd_pkg::COUNT_W-1:0]      s1_count;
  logic [prd_pkg::RGB_W-1:0]        rd_rgb;
  prd_pkg::pal_wr_t                 pal_wr;
  prd_pkg::pal_rd_t                 pal_rd;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_data  = (mode == prd_pkg::MODE_DATA);

  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    emit         = 1'b0;
    emit_kind    = prd_pkg::KIND_RUN;
    emit_idx     = data_byte;
    emit_count   = data_byte;
    if (mode == prd_pkg::MODE_RESTART) begin
      phase_next   = prd_pkg::PH_HEADER;
      pending_next = '0;
    end else if (is_data) begin
      unique case (phase)
        prd_pkg::PH_RUNCOL: begin
          emit         = (pending != '0);
          emit_count   = {1'b0, pending};
          phase_next   = prd_pkg::PH_HEADER;
          pending_next = '0;
        end
        prd_pkg::PH_FFLEN: begin
          emit         = (data_byte != '0);
          emit_idx     = prd_pkg::FILL_INDEX;
          phase_next   = prd_pkg::PH_HEADER;
          pending_next = '0;
        end
        prd_pkg::PH_LITERAL: begin
          emit       = 1'b1;
          emit_count = prd_pkg::COUNT_W'(1);
          if (pending <= prd_pkg::PEND_W'(1)) begin
            phase_next   = prd_pkg::PH_HEADER;
            pending_next = '0;
          end else begin
            pending_next = pending - prd_pkg::PEND_W'(1);
          end
        end
        prd_pkg::PH_REPLEN: begin
          emit         = (data_byte != '0);
          emit_kind    = prd_pkg::KIND_REPEAT;
          phase_next   = prd_pkg::PH_HEADER;
          pending_next = '0;
        end
        default: begin
          pending_next = data_byte[prd_pkg::PEND_W-1:0];
          if (data_byte[7]) begin
            phase_next = (data_byte[6:0] != '0) ? prd_pkg::PH_RUNCOL : prd_pkg::PH_FFLEN;
          end else begin
            phase_next = (data_byte[6:0] != '0) ? prd_pkg::PH_LITERAL : prd_pkg::PH_REPLEN;
          end
        end
      endcase
    end
  end

  assign pal_wr.en  = accept && (mode == prd_pkg::MODE_PAL_WRITE);
  assign pal_wr.idx = pal_index;
  assign pal_wr.rgb = {pal_red, pal_green, pal_blue};
  assign pal_rd.en  = accept && emit && (emit_kind == prd_pkg::KIND_RUN);
  assign pal_rd.idx = emit_idx;

  prd_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .rst    (rst),
    .wr     (pal_wr),
    .rd     (pal_rd),
    .rd_rgb (rd_rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= prd_pkg::PH_HEADER;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase   <= phase_next;
        pending <= pending_next;
      end
      if (accept) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_kind  <= emit_kind;
      s1_count <= emit_count;
    end
  end

  assign kind  = s1_kind;
  assign red   = (s1_kind == prd_pkg::KIND_REPEAT) ? 8'd0 : rd_rgb[23:16];
  assign green = (s1_kind == prd_pkg::KIND_REPEAT) ? 8'd0 : rd_rgb[15:8];
  assign blue  = (s1_kind == prd_pkg::KIND_REPEAT) ? 8'd0 : rd_rgb[7:0];
  assign count = s1_count;

endmodule
